@@ rtl/core/gtg_pkg.sv @@
// shared types, constants and tables for the go-to-goal heading controller
package gtg_pkg;

    // angle format Q3.13, carried in 18-bit signed words
    localparam int ANG_W = 18;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 18'sd25736;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 18'sd51472;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 18'sd12868;

    // cordic geometry
    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_IN_W  = 34;
    localparam int CORDIC_W     = 37;

    // shared multiplier operand widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_GOAL_X        = 3'd0,
        REG_GOAL_Y        = 3'd1,
        REG_LINEAR_GAIN   = 3'd2,
        REG_HEADING_GAIN  = 3'd3,
        REG_MAX_LINEAR    = 3'd4,
        REG_MAX_ANGULAR   = 3'd5,
        REG_ARRIVE_RADIUS = 3'd6
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_CHECK,
        ST_LIN,
        ST_CAP,
        ST_QMUL,
        ST_QCHK,
        ST_BEAR,
        ST_YAW,
        ST_ERR,
        ST_HMUL,
        ST_ANG,
        ST_OUT
    } state_t;

    // arctangent table, Q3.13
    function automatic logic [12:0] atan_lut(input logic [3:0] idx);
        logic [12:0] v;
        unique case (idx)
            4'd0:    v = 13'd6434;
            4'd1:    v = 13'd3798;
            4'd2:    v = 13'd2007;
            4'd3:    v = 13'd1019;
            4'd4:    v = 13'd511;
            4'd5:    v = 13'd256;
            4'd6:    v = 13'd128;
            4'd7:    v = 13'd64;
            4'd8:    v = 13'd32;
            4'd9:    v = 13'd16;
            4'd10:   v = 13'd8;
            4'd11:   v = 13'd4;
            4'd12:   v = 13'd2;
            4'd13:   v = 13'd1;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/gtg_if.sv @@
// valid/ready channel interfaces for pose samples and speed commands
interface gtg_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink (input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  output ready);
endinterface

interface gtg_cmd_if;
    logic               valid;
    logic               ready;
    logic        [30:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic               goal_reached;

    modport source (output valid, linear_cmd, angular_cmd, goal_reached, input ready);
    modport sink (input valid, linear_cmd, angular_cmd, goal_reached, output ready);
endinterface

@@ rtl/core/gtg_isqrt.sv @@
// iterative integer square root, two radicand bits per cycle
module gtg_isqrt
    import gtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [65:0] radicand,
    output logic        busy,
    output logic        done,
    output logic [32:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [65:0] rad_reg, rad_next;
    logic [35:0] rem_reg, rem_next;
    logic [32:0] root_reg, root_next;
    logic [37:0] rem_sh;
    logic [37:0] trial;

    // one restoring step
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[65:64]};
        trial     = {3'b000, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[63:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = 36'(rem_sh - trial);
                root_next = {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[35:0];
                root_next = {root_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd32)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/core/gtg_cordic.sv @@
// iterative vectoring cordic atan2, one micro-rotation per cycle
module gtg_cordic
    import gtg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [CORDIC_IN_W-1:0] y_in,
    input  logic signed [CORDIC_IN_W-1:0] x_in,
    output logic                          done,
    output logic signed [ANG_W-1:0]       angle
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [3:0]                 idx_reg, idx_next;
    logic                       zero_reg, zero_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0]    z_reg, z_next;
    logic signed [CORDIC_W-1:0] xi, yi, xs, ys;
    logic signed [ANG_W-1:0]    step_ang;

    // quadrant pre-rotation on start, then micro-rotations
    always_comb
    begin
        xi        = CORDIC_W'(x_in);
        yi        = CORDIC_W'(y_in);
        xs        = x_reg >>> idx_reg;
        ys        = y_reg >>> idx_reg;
        step_ang  = ANG_W'(atan_lut(idx_reg));
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        zero_next = zero_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = 4'd0;
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_next = yi;
                    y_next = -xi;
                    z_next = ANG_HALF_PI;
                end
                else
                begin
                    x_next = -yi;
                    y_next = xi;
                    z_next = -ANG_HALF_PI;
                end
            end
            else
            begin
                x_next = xi;
                y_next = yi;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_ang;
            end
            idx_next = idx_reg + 4'd1;
            if (idx_reg == 4'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // atan2 of the origin is zero
    assign done  = done_reg;
    assign angle = zero_reg ? '0 : z_reg;

endmodule

@@ rtl/core/go_to_goal_heading_controller.sv @@
// Go-to-goal controller top level: one pose transaction in, at most one
// command transaction out. A pose taken while inactive is dropped at once.
// An active pose keeps the sequencer busy through the squares and their sum,
// the bit-pair square-root unit, the radius check, the linear product and
// cap, 8 quaternion products through the one shared multiplier, the yaw
// operands, two runs of the cordic unit, and the heading error, product,
// clamp and hand-off to the output register. A pose that reaches the goal
// leaves after the radius check. The pose side is ready only in the idle
// state, so the next pose is taken in the cycle after the hand-off at the
// earliest; a finished command waits in the output register while the next
// pose is taken, and the sequencer holds in its last state while an earlier
// command is still waiting. Writing goal x or goal y re-arms the controller.
module go_to_goal_heading_controller
    import gtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gtg_pose_if.sink    pose,
    gtg_cmd_if.source   cmd,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;

    // configuration and mode
    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic [15:0]        lin_gain_reg, head_gain_reg;
    logic [30:0]        max_lin_reg, max_ang_reg, radius_reg;
    logic               active_reg;

    // working registers
    logic signed [32:0]      dx_reg, dy_reg;
    logic signed [15:0]      qx_reg, qy_reg, qz_reg, qw_reg;
    logic [64:0]             sq_reg;
    logic [64:0]             acc_reg;
    logic [32:0]             d_reg;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic [30:0]             lin_reg;
    logic signed [31:0]      qp_reg [8];
    logic [2:0]              qidx_reg, qidx_next;
    logic signed [33:0]      cx_reg, cy_reg;
    logic                    yawz_reg;
    logic signed [ANG_W-1:0] bear_reg, yaw_reg, err_reg;
    logic signed [31:0]      ang_reg;
    logic                    stop_reg;

    // output register
    logic               out_valid_reg;
    logic [30:0]        out_lin_reg;
    logic signed [31:0] out_ang_reg;
    logic               out_reached_reg;

    logic accept, out_free;
    assign accept   = pose.valid && pose.ready;
    assign out_free = !out_valid_reg || cmd.ready;
    assign pose.ready = (state_reg == ST_IDLE);

    // square of a 33-bit magnitude; top bit set means low bits are zero
    logic [32:0] abs_x, abs_y, abs_sel;
    logic [63:0] sq_mag;
    logic [64:0] sq_val;
    assign abs_x   = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign abs_y   = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign abs_sel = (state_reg == ST_SQX) ? abs_x : abs_y;
    assign sq_mag  = abs_sel[31:0] * abs_sel[31:0];
    assign sq_val  = abs_sel[32] ? {1'b1, 64'd0} : {1'b0, sq_mag};

    // shared signed multiplier operand selection
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [15:0]        qa, qb;
    always_comb
    begin
        unique case (qidx_reg)
            3'd0:    begin qa = qw_reg; qb = qw_reg; end
            3'd1:    begin qa = qx_reg; qb = qx_reg; end
            3'd2:    begin qa = qy_reg; qb = qy_reg; end
            3'd3:    begin qa = qz_reg; qb = qz_reg; end
            3'd4:    begin qa = qx_reg; qb = qz_reg; end
            3'd5:    begin qa = qw_reg; qb = qy_reg; end
            3'd6:    begin qa = qx_reg; qb = qy_reg; end
            default: begin qa = qw_reg; qb = qz_reg; end
        endcase
        priority if (state_reg == ST_LIN)
        begin
            mul_a = $signed({1'b0, d_reg});
            mul_b = $signed({1'b0, lin_gain_reg});
        end
        else if (state_reg == ST_HMUL)
        begin
            mul_a = MUL_A_W'(err_reg);
            mul_b = $signed({1'b0, head_gain_reg});
        end
        else
        begin
            mul_a = MUL_A_W'(qa);
            mul_b = MUL_B_W'(qb);
        end
    end
    assign mul_p = mul_a * mul_b;

    // yaw operands and gimbal-lock test from the quaternion products
    logic signed [33:0] norm, sp, sp_abs, cx_val, cy_val;
    assign norm   = 34'(qp_reg[0]) + 34'(qp_reg[1]) + 34'(qp_reg[2]) + 34'(qp_reg[3]);
    assign sp     = 34'(34'(qp_reg[4]) - 34'(qp_reg[5])) <<< 1;
    assign sp_abs = sp[33] ? -sp : sp;
    assign cx_val = 34'(qp_reg[0]) + 34'(qp_reg[1]) - 34'(qp_reg[2]) - 34'(qp_reg[3]);
    assign cy_val = 34'(34'(qp_reg[6]) + 34'(qp_reg[7])) <<< 1;

    // square root unit
    logic        sq_start, sq_busy, sq_done;
    logic [32:0] sq_root;
    assign sq_start = (state_reg == ST_SUM);

    gtg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({1'b0, acc_reg} + {1'b0, sq_reg}),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    // cordic unit, bearing first then yaw
    logic                          cor_start, cor_done;
    logic signed [CORDIC_IN_W-1:0] cor_y, cor_x;
    logic signed [ANG_W-1:0]       cor_ang;
    assign cor_start = (state_reg == ST_QCHK) || (state_reg == ST_BEAR && cor_done);
    assign cor_y     = (state_reg == ST_QCHK) ? CORDIC_IN_W'(dy_reg) : cy_reg;
    assign cor_x     = (state_reg == ST_QCHK) ? CORDIC_IN_W'(dx_reg) : cx_reg;

    gtg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cor_done),
        .angle (cor_ang)
    );

    // heading error and command arithmetic
    logic signed [ANG_W:0]     err_raw;
    logic [42:0]               lin_full;
    logic signed [MUL_P_W-1:0] ang_full, amax;
    assign err_raw  = (ANG_W+1)'(bear_reg) - (ANG_W+1)'(yaw_reg);
    assign lin_full = prod_reg[MUL_P_W-1:8];
    assign ang_full = prod_reg >>> 5;
    assign amax     = $signed({20'd0, max_ang_reg});

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        qidx_next  = qidx_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept && active_reg) state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_ROOT;
            ST_ROOT:  if (sq_done) state_next = ST_CHECK;
            ST_CHECK: state_next = ({2'b00, radius_reg} >= d_reg) ? ST_OUT : ST_LIN;
            ST_LIN:   state_next = ST_CAP;
            ST_CAP:
            begin
                state_next = ST_QMUL;
                qidx_next  = 3'd0;
            end
            ST_QMUL:
            begin
                qidx_next = qidx_reg + 3'd1;
                if (qidx_reg == 3'd7) state_next = ST_QCHK;
            end
            ST_QCHK:  state_next = ST_BEAR;
            ST_BEAR:  if (cor_done) state_next = ST_YAW;
            ST_YAW:   if (cor_done) state_next = ST_ERR;
            ST_ERR:   state_next = ST_HMUL;
            ST_HMUL:  state_next = ST_ANG;
            ST_ANG:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            qidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            qidx_reg  <= qidx_next;
        end
    end

    // configuration registers and active flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            lin_gain_reg  <= 16'd256;
            head_gain_reg <= 16'd256;
            max_lin_reg   <= 31'd65536;
            max_ang_reg   <= 31'd65536;
            radius_reg    <= 31'd6554;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CHECK && {2'b00, radius_reg} >= d_reg)
                active_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GOAL_X:
                    begin
                        goal_x_reg <= cfg_data;
                        active_reg <= 1'b1;
                    end
                    REG_GOAL_Y:
                    begin
                        goal_y_reg <= cfg_data;
                        active_reg <= 1'b1;
                    end
                    REG_LINEAR_GAIN:   lin_gain_reg  <= cfg_data[15:0];
                    REG_HEADING_GAIN:  head_gain_reg <= cfg_data[15:0];
                    REG_MAX_LINEAR:    max_lin_reg   <= cfg_data[30:0];
                    REG_MAX_ANGULAR:   max_ang_reg   <= cfg_data[30:0];
                    REG_ARRIVE_RADIUS: radius_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= 33'(goal_x_reg) - 33'(pose.pos_x);
            dy_reg <= 33'(goal_y_reg) - 33'(pose.pos_y);
            qx_reg <= pose.quat_x;
            qy_reg <= pose.quat_y;
            qz_reg <= pose.quat_z;
            qw_reg <= pose.quat_w;
        end
        if (state_reg == ST_SQX) acc_reg <= sq_val;
        if (state_reg == ST_SQY) sq_reg <= sq_val;
        if (state_reg == ST_ROOT && sq_done) d_reg <= sq_root;
        if (state_reg == ST_CHECK) stop_reg <= ({2'b00, radius_reg} >= d_reg);
        if (state_reg == ST_LIN || state_reg == ST_HMUL) prod_reg <= mul_p;
        if (state_reg == ST_CAP)
            lin_reg <= (lin_full > {12'd0, max_lin_reg}) ? max_lin_reg : lin_full[30:0];
        if (state_reg == ST_QMUL) qp_reg[qidx_reg] <= mul_p[31:0];
        if (state_reg == ST_QCHK)
        begin
            cx_reg   <= cx_val;
            cy_reg   <= cy_val;
            yawz_reg <= (norm == '0) || (sp_abs >= norm);
        end
        if (state_reg == ST_BEAR && cor_done)
            bear_reg <= cor_ang[ANG_W-1] ? cor_ang + ANG_TWO_PI : cor_ang;
        if (state_reg == ST_YAW && cor_done)
            yaw_reg <= yawz_reg ? '0 : cor_ang;
        if (state_reg == ST_ERR)
            err_reg <= (err_raw > (ANG_W+1)'(ANG_PI)) ?
                       ANG_W'(err_raw - (ANG_W+1)'(ANG_TWO_PI)) : ANG_W'(err_raw);
        if (state_reg == ST_ANG)
        begin
            priority if (ang_full > amax)
                ang_reg <= 32'(amax);
            else if (ang_full < -amax)
                ang_reg <= 32'(-amax);
            else
                ang_reg <= 32'(ang_full);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (cmd.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_lin_reg     <= stop_reg ? '0 : lin_reg;
            out_ang_reg     <= stop_reg ? '0 : ang_reg;
            out_reached_reg <= stop_reg;
        end
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.linear_cmd   = out_lin_reg;
    assign cmd.angular_cmd  = out_ang_reg;
    assign cmd.goal_reached = out_reached_reg;

    // a pose taken while inactive produces no work
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !active_reg |=> state_reg == ST_IDLE)
        else $error("inactive pose started the sequencer");

    // the stop command carries zero speeds
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.goal_reached |-> cmd.linear_cmd == '0 && cmd.angular_cmd == '0)
        else $error("stop command with non-zero speed");

    // the root unit only runs while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_busy |-> state_reg == ST_ROOT)
        else $error("square root unit busy outside its wait state");

endmodule
